[hw/rtl/bpfa_pkg.sv]
// Shared types and constants for the bitmap page frame allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bpfa_pkg;

  localparam int CNT_W  = 21;
  localparam int PAGE_W = 20;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [PAGE_W-1:0] page;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] reserved;
    logic             init;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/bpfa_queue.sv]
// Two-entry request queue between the front and back parts.
// Depends on bpfa_pkg for the request type.
`default_nettype none

module bpfa_queue
  import bpfa_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  req_t push_data,
  input  wire  pop,
  output logic full,
  output logic valid,
  output req_t head
);

  logic [1:0] cnt_r, cnt_nxt;
  req_t       e0_r, e0_nxt;
  req_t       e1_r, e1_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = e0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (pop) begin
      e0_nxt = e1_r;
    end
    if (push) begin
      if ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop)) begin
        e0_nxt = push_data;
      end else begin
        e1_nxt = push_data;
      end
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/bpfa_front.sv]
// Front part: accepts requests and classifies them as allocate, free or reject.
// Depends on bpfa_pkg for the request type and operation codes.
`default_nettype none

module bpfa_front
  import bpfa_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_func,
  input  wire   [PAGE_W-1:0] in_page,
  input  wire   [CNT_W-1:0]  limit,
  input  wire                clearing,
  input  wire                q_full,
  output logic               push,
  output req_t               push_data
);

  logic seen_r;

  assign in_stall = clearing || q_full || !seen_r;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_data.page = in_page;
    if (!in_func) begin
      push_data.op = OP_ALLOC;
    end else if ({1'b0, in_page} < limit) begin
      push_data.op = OP_FREE;
    end else begin
      push_data.op = OP_REJECT;
    end
  end

  // Holds off requests while seen_r is low after reset, until the clearing pass is visible.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bpfa_back.sv]
// Back part: used-page bitmap memory, search hint, word scan and clearing pass.
// Depends on bpfa_pkg for the request and configuration types.
`default_nettype none

module bpfa_back
  import bpfa_pkg::*;
#(
  parameter int MAX_PAGES     = 1048576,
  parameter int MAP_WORD_BITS = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  cfg_t               cfg,
  input  wire                q_valid,
  input  req_t               q_head,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  input  wire                out_stall,
  output logic  [PAGE_W-1:0] out_granted_page,
  output logic               out_ok
);

  localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(MAP_WORD_BITS);
  localparam int SW        = CNT_W + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;

  logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] rdata_r;

  logic [2:0]        st_r, st_nxt;
  logic [AW-1:0]     waddr_r, waddr_nxt;
  logic [CNT_W-1:0]  base_r, base_nxt;
  logic              first_r, first_nxt;
  logic [BW-1:0]     bit_r, bit_nxt;
  logic [CNT_W-1:0]  fpage_r, fpage_nxt;
  logic [CNT_W-1:0]  hint_r, hint_nxt;
  logic              ov_r, ov_nxt;
  logic [PAGE_W-1:0] og_r, og_nxt;
  logic              ok_r, ok_nxt;

  logic [AW-1:0]            raddr;
  logic                     we;
  logic [AW-1:0]            wa;
  logic [MAP_WORD_BITS-1:0] wd;

  logic [CNT_W-1:0]         hw_word, hw_base, rq_page, rq_word, rq_bit;
  logic [CNT_W-1:0]         lo, rem;
  logic [BW:0]              hi;
  logic [MAP_WORD_BITS-1:0] vmask, cand, clr_word;
  logic                     found;
  logic [BW-1:0]            fidx;
  logic [CNT_W-1:0]         gpage;

  assign clearing         = (st_r == S_CLEAR);
  assign out_valid        = ov_r;
  assign out_granted_page = og_r;
  assign out_ok           = ok_r;

  assign hw_word = CNT_W'(hint_r / MAP_WORD_BITS);
  assign hw_base = CNT_W'(hint_r - CNT_W'(hint_r % MAP_WORD_BITS));
  assign rq_page = {1'b0, q_head.page};
  assign rq_word = CNT_W'(rq_page / MAP_WORD_BITS);
  assign rq_bit  = CNT_W'(rq_page % MAP_WORD_BITS);

  assign lo  = first_r ? (hint_r - base_r) : '0;
  assign rem = cfg.limit - base_r;
  assign hi  = (rem >= CNT_W'(MAP_WORD_BITS)) ? (BW+1)'(MAP_WORD_BITS) : rem[BW:0];

  always_comb begin
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      vmask[j]    = (CNT_W'(j) >= lo) && ((BW+1)'(j) < hi);
      clr_word[j] = (SW'(base_r) + SW'(j)) < SW'(cfg.reserved);
    end
    cand  = ~rdata_r & vmask;
    found = |cand;
    fidx  = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        fidx = BW'(j);
      end
    end
  end

  assign gpage = base_r + CNT_W'(fidx);

  always_comb begin
    st_nxt    = st_r;
    waddr_nxt = waddr_r;
    base_nxt  = base_r;
    first_nxt = first_r;
    bit_nxt   = bit_r;
    fpage_nxt = fpage_r;
    hint_nxt  = hint_r;
    ov_nxt    = ov_r && out_stall;
    og_nxt    = og_r;
    ok_nxt    = ok_r;
    raddr     = waddr_r;
    we        = 1'b0;
    wa        = waddr_r;
    wd        = '0;
    pop       = 1'b0;
    case (st_r)
      S_CLEAR: begin
        we = 1'b1;
        wd = clr_word;
        waddr_nxt = waddr_r + AW'(1);
        base_nxt  = base_r + CNT_W'(MAP_WORD_BITS);
        if (waddr_r == AW'(MAP_WORDS - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && !ov_r) begin
          pop = 1'b1;
          case (q_head.op)
            OP_ALLOC: begin
              if (hint_r >= cfg.limit) begin
                ov_nxt = 1'b1;
                og_nxt = '0;
                ok_nxt = 1'b0;
              end else begin
                raddr     = AW'(hw_word);
                waddr_nxt = AW'(hw_word);
                base_nxt  = hw_base;
                first_nxt = 1'b1;
                st_nxt    = S_SCAN;
              end
            end
            OP_FREE: begin
              raddr     = AW'(rq_word);
              waddr_nxt = AW'(rq_word);
              bit_nxt   = BW'(rq_bit);
              fpage_nxt = rq_page;
              st_nxt    = S_FREE;
            end
            default: begin
              ov_nxt = 1'b1;
              og_nxt = '0;
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        raddr = waddr_r + AW'(1);
        if (found) begin
          we = 1'b1;
          wd = rdata_r | (MAP_WORD_BITS'(1) << fidx);
          hint_nxt = gpage + CNT_W'(1);
          ov_nxt   = 1'b1;
          og_nxt   = gpage[PAGE_W-1:0];
          ok_nxt   = 1'b1;
          st_nxt   = S_IDLE;
        end else if ((SW'(base_r) + SW'(MAP_WORD_BITS)) >= SW'(cfg.limit)) begin
          ov_nxt = 1'b1;
          og_nxt = '0;
          ok_nxt = 1'b0;
          st_nxt = S_IDLE;
        end else begin
          waddr_nxt = waddr_r + AW'(1);
          base_nxt  = base_r + CNT_W'(MAP_WORD_BITS);
          first_nxt = 1'b0;
        end
      end
      S_FREE: begin
        we = 1'b1;
        wd = rdata_r & ~(MAP_WORD_BITS'(1) << bit_r);
        if (fpage_r < hint_r) begin
          hint_nxt = fpage_r;
        end
        ov_nxt = 1'b1;
        og_nxt = '0;
        ok_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    if (cfg.init) begin
      st_nxt    = S_CLEAR;
      waddr_nxt = '0;
      base_nxt  = '0;
      hint_nxt  = cfg.reserved;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      waddr_r <= '0;
      base_r  <= '0;
      hint_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      waddr_r <= waddr_nxt;
      base_r  <= base_nxt;
      hint_r  <= hint_nxt;
      ov_r    <= ov_nxt;
    end
    first_r <= first_nxt;
    bit_r   <= bit_nxt;
    fpage_r <= fpage_nxt;
    og_r    <= og_nxt;
    ok_r    <= ok_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/bitmap_page_frame_allocator_top.sv]
// A rejected free, or an allocation while the hint is at or above the page count, is
// answered without the bitmap; a free updates one word, an allocation scans from the hint.
// One request is carried out at a time; the next starts in the cycle after its result is taken.
// After reset and after every register write a clearing pass writes every bitmap word,
// during which in_stall stays high.
// Depends on bpfa_pkg, bpfa_front, bpfa_queue and bpfa_back.
`default_nettype none

module bitmap_page_frame_allocator_top
  import bpfa_pkg::*;
#(
  parameter int MAX_PAGES     = 1048576,
  parameter int MAP_WORD_BITS = 32
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_func,
  input  wire  [PAGE_W-1:0] in_page,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [PAGE_W-1:0] out_granted_page,
  output logic              out_ok,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [2:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;
  localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_PAGES);

  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] reserved_r, reserved_nxt;
  logic [CNT_W-1:0] lim_c, res_c;
  logic             wr;
  cfg_t             cfg;
  logic             clearing, q_full, q_valid, push, pop;
  req_t             push_data, q_head;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    total_nxt    = total_r;
    reserved_nxt = reserved_r;
    if (wr) begin
      case (paddr[2])
        REG_TOTAL:    total_nxt    = pwdata[CNT_W-1:0];
        REG_RESERVED: reserved_nxt = pwdata[CNT_W-1:0];
        default:      total_nxt    = total_r;
      endcase
    end
    case (paddr[2])
      REG_TOTAL:    prdata = {{(32-CNT_W){1'b0}}, total_r};
      REG_RESERVED: prdata = {{(32-CNT_W){1'b0}}, reserved_r};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      reserved_r <= '0;
    end else begin
      total_r    <= total_nxt;
      reserved_r <= reserved_nxt;
    end
  end

  // The reserved count follows the value being written so that the new hint is taken from it.
  assign lim_c = (total_r > MAXP) ? MAXP : total_r;
  assign res_c = (reserved_nxt > MAXP) ? MAXP : reserved_nxt;
  assign cfg   = '{limit: lim_c, reserved: res_c, init: wr};

  bpfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_page   (in_page),
    .limit     (cfg.limit),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bpfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  bpfa_back #(
    .MAX_PAGES     (MAX_PAGES),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .pop              (pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_page (out_granted_page),
    .out_ok           (out_ok)
  );

endmodule

`default_nettype wire

[hw/rtl/bpfa_checker.sv]
// Port-level checks for the bitmap page frame allocator, bound to the top level.
// Depends on bpfa_pkg for field widths.
`default_nettype none

module bpfa_checker
  import bpfa_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              in_valid,
  input wire              in_stall,
  input wire              in_func,
  input wire [PAGE_W-1:0] in_page,
  input wire              out_valid,
  input wire              out_stall,
  input wire [PAGE_W-1:0] out_granted_page,
  input wire              out_ok,
  input wire              psel,
  input wire              penable,
  input wire              pwrite
);

  // A stalled request transaction holds its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_func) && $stable(in_page))
    else $error("request transaction changed while stalled");

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted_page) && $stable(out_ok))
    else $error("result transaction changed while stalled");

  // A failed result never carries a page number.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_granted_page == '0)
    else $error("failed result carries a page");

  // Reset starts the clearing pass, so no request is taken right after it.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during clearing after reset");

  // A register write starts a fresh clearing pass.
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=> in_stall)
    else $error("request taken during clearing after a register write");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker u_bpfa_checker (.*);

`default_nettype wire
